// ----- hdl/jpic_pkg.sv -----
// Shared types and constants for the JSON payload integrity checker.
`default_nettype none

package jpic_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int MAX_BYTES_W         = 16;
   localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 16'd4096;

   localparam logic [7:0] OPEN_BRACE  = 8'h7B;
   localparam logic [7:0] CLOSE_BRACE = 8'h7D;
   localparam logic [7:0] QUOTE_CHAR  = 8'h22;
   localparam logic [7:0] ESC_CHAR    = 8'h5C;
   localparam logic [7:0] WS_LIMIT    = 8'h20;

   typedef enum logic [2:0] {
      REASON_OK         = 3'd0,
      REASON_TOO_LONG   = 3'd1,
      REASON_BLANK      = 3'd2,
      REASON_FRAMING    = 3'd3,
      REASON_UNDERFLOW  = 3'd4,
      REASON_UNBALANCED = 3'd5
   } reason_type;

   typedef struct packed {
      logic       seen_content;
      logic       first_is_open;
      logic [7:0] last_content_byte;
      logic       inside_string;
      logic       escape_pending;
      logic       underflow_seen;
   } scan_flags_type;

endpackage

`default_nettype wire

// ----- hdl/jpic_scan.sv -----
// Per-byte scan update and end-of-payload verdict.
`default_nettype none

module jpic_scan #(
   parameter int LENGTH_BITS = jpic_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic [7:0]                         data_byte,
   input  wire jpic_pkg::scan_flags_type           flags_cur,
   input  wire logic [LENGTH_BITS:0]               count_cur,
   input  wire logic [LENGTH_BITS:0]               depth_cur,
   input  wire logic [jpic_pkg::MAX_BYTES_W-1:0]   max_payload_bytes,
   output jpic_pkg::scan_flags_type                flags_next,
   output logic [LENGTH_BITS:0]                    count_next,
   output logic [LENGTH_BITS:0]                    depth_next,
   output jpic_pkg::reason_type                    reason
);

   localparam int CNT_W = LENGTH_BITS + 1;
   localparam int CMP_W = (CNT_W > jpic_pkg::MAX_BYTES_W) ? CNT_W : jpic_pkg::MAX_BYTES_W;
   localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};

   logic is_content;
   logic too_long;

   assign is_content = data_byte > jpic_pkg::WS_LIMIT;
   assign too_long   = CMP_W'(count_next) > CMP_W'(max_payload_bytes);

   always_comb begin
      flags_next = flags_cur;
      depth_next = depth_cur;
      count_next = (count_cur != CNT_CAP) ? count_cur + CNT_W'(1) : count_cur;

      if (is_content) begin
         if (!flags_cur.seen_content) begin
            flags_next.first_is_open = (data_byte == jpic_pkg::OPEN_BRACE);
         end
         flags_next.seen_content      = 1'b1;
         flags_next.last_content_byte = data_byte;
      end

      // string tracking first; braces count only outside strings
      if (flags_cur.inside_string) begin
         if (flags_cur.escape_pending) begin
            flags_next.escape_pending = 1'b0;
         end else if (data_byte == jpic_pkg::ESC_CHAR) begin
            flags_next.escape_pending = 1'b1;
         end else if (data_byte == jpic_pkg::QUOTE_CHAR) begin
            flags_next.inside_string = 1'b0;
         end
      end else if (data_byte == jpic_pkg::QUOTE_CHAR) begin
         flags_next.inside_string = 1'b1;
      end else if (data_byte == jpic_pkg::OPEN_BRACE) begin
         if (depth_cur != CNT_CAP) begin
            depth_next = depth_cur + CNT_W'(1);
         end
      end else if (data_byte == jpic_pkg::CLOSE_BRACE) begin
         if (depth_cur == '0) begin
            flags_next.underflow_seen = 1'b1;
         end else begin
            depth_next = depth_cur - CNT_W'(1);
         end
      end
   end

   always_comb begin
      priority if (too_long) begin
         reason = jpic_pkg::REASON_TOO_LONG;
      end else if (!flags_next.seen_content) begin
         reason = jpic_pkg::REASON_BLANK;
      end else if (!flags_next.first_is_open ||
                   flags_next.last_content_byte != jpic_pkg::CLOSE_BRACE) begin
         reason = jpic_pkg::REASON_FRAMING;
      end else if (flags_next.underflow_seen) begin
         reason = jpic_pkg::REASON_UNDERFLOW;
      end else if (depth_next != '0 || flags_next.inside_string) begin
         reason = jpic_pkg::REASON_UNBALANCED;
      end else begin
         reason = jpic_pkg::REASON_OK;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/json_payload_integrity_check.sv -----
// JSON payload integrity checker: top level with scan state and result register.
//
// Usage: bytes of one payload arrive on the req_ channel (req_data_byte,
// req_last_byte marks the final byte), one per cycle when req_valid and
// req_ready are both high. Only the final byte yields an item on the rsp_
// channel: rsp_intact and rsp_fail_reason (0 ok, 1 too long, 2 blank,
// 3 bad framing, 4 underflow, 5 unbalanced or unclosed).
// Latency: the result is valid the cycle after the final byte is accepted.
// Throughput: one byte per cycle while req_ready is high; the next scan state
// is combinational in the counters and flags; payloads follow back to back.
// Stall: the result register holds until rsp_ready; req_ready stays high
// while the register is empty or is being drained in the same cycle.
// csr_wr_en/csr_wr_data set the maximum payload length; write only while idle.
// Reset: synchronous, active high; clears the scan state and rsp_valid (not the
// stored reason), sets the maximum length to 4096. No clearing pass is needed.
`default_nettype none

module json_payload_integrity_check #(
   parameter int LENGTH_BITS = jpic_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_data_byte,
   input  wire logic                              req_last_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_intact,
   output logic [2:0]                             rsp_fail_reason,
   input  wire logic                              csr_wr_en,
   input  wire logic [jpic_pkg::MAX_BYTES_W-1:0]  csr_wr_data
);

   localparam int CNT_W = LENGTH_BITS + 1;

   logic [jpic_pkg::MAX_BYTES_W-1:0] max_bytes_ff;
   jpic_pkg::scan_flags_type         flags_ff, flags_in, flags_scan;
   logic [CNT_W-1:0]                 count_ff, count_in, count_scan;
   logic [CNT_W-1:0]                 depth_ff, depth_in, depth_scan;
   jpic_pkg::reason_type             reason_scan;
   jpic_pkg::reason_type             reason_ff, reason_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   jpic_scan #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_scan (
      .data_byte         (req_data_byte),
      .flags_cur         (flags_ff),
      .count_cur         (count_ff),
      .depth_cur         (depth_ff),
      .max_payload_bytes (max_bytes_ff),
      .flags_next        (flags_scan),
      .count_next        (count_scan),
      .depth_next        (depth_scan),
      .reason            (reason_scan)
   );

   always_comb begin
      flags_in     = flags_ff;
      count_in     = count_ff;
      depth_in     = depth_ff;
      reason_in    = reason_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         if (req_last_byte) begin
            // start the next payload from a clean slate
            flags_in     = '0;
            count_in     = '0;
            depth_in     = '0;
            reason_in    = reason_scan;
            rsp_valid_in = 1'b1;
         end else begin
            flags_in = flags_scan;
            count_in = count_scan;
            depth_in = depth_scan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= jpic_pkg::MAX_BYTES_RESET;
         flags_ff     <= '0;
         count_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_bytes_ff <= csr_wr_data;
         end
         flags_ff     <= flags_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reason_ff <= reason_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fail_reason = reason_ff;
   assign rsp_intact      = (reason_ff == jpic_pkg::REASON_OK);

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for the JSON payload integrity checker: directed table, then random payloads.
`default_nettype none

module tb;

   localparam int SCAN_W = jpic_pkg::LENGTH_BITS_DEFAULT + 1;
   localparam logic [SCAN_W-1:0] SCAN_CAP = '1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_GOAL = 1200;
   localparam int DIR_N = 24;

   typedef struct packed {
      logic [7:0]           b;
      logic                 last;
      logic                 typed;
      jpic_pkg::reason_type why;
   } dir_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [7:0]                       req_data_byte;
   logic                             req_last_byte;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_intact;
   logic [2:0]                       rsp_fail_reason;
   logic                             csr_wr_en;
   logic [jpic_pkg::MAX_BYTES_W-1:0] csr_wr_data;

   // scan state of the predictor
   logic [jpic_pkg::MAX_BYTES_W-1:0] max_bytes_model = jpic_pkg::MAX_BYTES_RESET;
   logic [SCAN_W-1:0]                scan_count = '0;
   logic [SCAN_W-1:0]                scan_depth = '0;
   jpic_pkg::scan_flags_type         scan_flags = '0;

   jpic_pkg::reason_type verdict_q[$];
   logic [7:0]           frame_q[$];
   int                   fault_count = 0;
   int                   random_bytes = 0;
   int                   cycle_count = 0;
   int                   rsp_hold = 0;
   bit                   rsp_eager = 1'b0;

   // " {}\n", blanks, stray content, underflow, open brace, open string, escaped quote
   dir_row_type dir_rows [DIR_N] = '{
      '{8'h20,                 1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::OPEN_BRACE,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::CLOSE_BRACE, 1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{8'h0A,                 1'b1, 1'b1, jpic_pkg::REASON_OK},
      '{8'h20,                 1'b1, 1'b1, jpic_pkg::REASON_BLANK},
      '{8'h00,                 1'b1, 1'b1, jpic_pkg::REASON_BLANK},
      '{8'h21,                 1'b1, 1'b1, jpic_pkg::REASON_FRAMING},
      '{8'hFF,                 1'b1, 1'b1, jpic_pkg::REASON_FRAMING},
      '{jpic_pkg::OPEN_BRACE,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::CLOSE_BRACE, 1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::CLOSE_BRACE, 1'b1, 1'b1, jpic_pkg::REASON_UNDERFLOW},
      '{jpic_pkg::OPEN_BRACE,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::OPEN_BRACE,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::CLOSE_BRACE, 1'b1, 1'b1, jpic_pkg::REASON_UNBALANCED},
      '{jpic_pkg::OPEN_BRACE,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::QUOTE_CHAR,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::CLOSE_BRACE, 1'b1, 1'b1, jpic_pkg::REASON_UNBALANCED},
      '{jpic_pkg::OPEN_BRACE,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::QUOTE_CHAR,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::ESC_CHAR,    1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::QUOTE_CHAR,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::CLOSE_BRACE, 1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::QUOTE_CHAR,  1'b0, 1'b0, jpic_pkg::REASON_OK},
      '{jpic_pkg::CLOSE_BRACE, 1'b1, 1'b0, jpic_pkg::REASON_OK}
   };

   json_payload_integrity_check u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_intact      (rsp_intact),
      .rsp_fail_reason (rsp_fail_reason),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Advance the scan state by one byte; on the last byte give the verdict and clear.
   function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                    output jpic_pkg::reason_type why);
      why = jpic_pkg::REASON_OK;
      if (scan_count != SCAN_CAP) scan_count = scan_count + 1'b1;
      if (b > jpic_pkg::WS_LIMIT) begin
         if (!scan_flags.seen_content)
            scan_flags.first_is_open = (b == jpic_pkg::OPEN_BRACE);
         scan_flags.seen_content = 1'b1;
         scan_flags.last_content_byte = b;
      end
      if (scan_flags.inside_string) begin
         if (scan_flags.escape_pending) scan_flags.escape_pending = 1'b0;
         else if (b == jpic_pkg::ESC_CHAR) scan_flags.escape_pending = 1'b1;
         else if (b == jpic_pkg::QUOTE_CHAR) scan_flags.inside_string = 1'b0;
      end else if (b == jpic_pkg::QUOTE_CHAR) begin
         scan_flags.inside_string = 1'b1;
      end else if (b == jpic_pkg::OPEN_BRACE) begin
         if (scan_depth != SCAN_CAP) scan_depth = scan_depth + 1'b1;
      end else if (b == jpic_pkg::CLOSE_BRACE) begin
         if (scan_depth == '0) scan_flags.underflow_seen = 1'b1;
         else scan_depth = scan_depth - 1'b1;
      end
      if (!last) return 1'b0;
      if (scan_count > {1'b0, max_bytes_model}) why = jpic_pkg::REASON_TOO_LONG;
      else if (!scan_flags.seen_content) why = jpic_pkg::REASON_BLANK;
      else if (!scan_flags.first_is_open ||
               scan_flags.last_content_byte != jpic_pkg::CLOSE_BRACE)
         why = jpic_pkg::REASON_FRAMING;
      else if (scan_flags.underflow_seen) why = jpic_pkg::REASON_UNDERFLOW;
      else if (scan_depth != '0 || scan_flags.inside_string)
         why = jpic_pkg::REASON_UNBALANCED;
      scan_count = '0;
      scan_depth = '0;
      scan_flags = '0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_blank();
      return 8'($urandom_range(0, 32));
   endfunction

   function automatic logic [7:0] pick_struct();
      case ($urandom_range(0, 3))
         0: return jpic_pkg::OPEN_BRACE;
         1: return jpic_pkg::CLOSE_BRACE;
         2: return jpic_pkg::QUOTE_CHAR;
         default: return jpic_pkg::ESC_CHAR;
      endcase
   endfunction

   // Offer one byte after gap idle cycles; hold valid until the handshake.
   task automatic push_byte(input logic [7:0] b, input logic last, input int gap,
                            input bit typed = 1'b0,
                            input jpic_pkg::reason_type typed_why = jpic_pkg::REASON_OK);
      jpic_pkg::reason_type why;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      if (scan_byte(b, last, why)) verdict_q.push_back(typed ? typed_why : why);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_max(input logic [jpic_pkg::MAX_BYTES_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_bytes_model = value;
   endtask

   // Mostly well-formed objects with random content; some broken, noise or blank.
   task automatic build_payload();
      int kind, depth, n, pos;
      logic [7:0] c;
      frame_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 12))
            frame_q.push_back($urandom_range(0, 1) ? pick_struct() : 8'($urandom_range(0, 255)));
      end else if (kind < 15) begin
         repeat ($urandom_range(1, 6)) frame_q.push_back(pick_blank());
      end else begin
         n = (kind >= 95) ? $urandom_range(20, 60) : $urandom_range(0, 10);
         repeat ($urandom_range(0, 2)) frame_q.push_back(pick_blank());
         frame_q.push_back(jpic_pkg::OPEN_BRACE);
         depth = 1;
         repeat (n) begin
            case ($urandom_range(0, 5))
               0: if (depth < 6) begin
                  frame_q.push_back(jpic_pkg::OPEN_BRACE);
                  depth++;
               end
               1: if (depth > 1) begin
                  frame_q.push_back(jpic_pkg::CLOSE_BRACE);
                  depth--;
               end
               2: begin
                  frame_q.push_back(jpic_pkg::QUOTE_CHAR);
                  repeat ($urandom_range(0, 6)) begin
                     c = 8'($urandom_range(0, 255));
                     // escape quotes and backslashes, and now and then any byte
                     if (c == jpic_pkg::QUOTE_CHAR || c == jpic_pkg::ESC_CHAR ||
                         $urandom_range(0, 4) == 0)
                        frame_q.push_back(jpic_pkg::ESC_CHAR);
                     frame_q.push_back(c);
                  end
                  frame_q.push_back(jpic_pkg::QUOTE_CHAR);
               end
               3: frame_q.push_back(pick_blank());
               default: begin
                  c = 8'($urandom_range(0, 255));
                  if (c == jpic_pkg::QUOTE_CHAR || c == jpic_pkg::OPEN_BRACE ||
                      c == jpic_pkg::CLOSE_BRACE) c = 8'h3A;
                  frame_q.push_back(c);
               end
            endcase
         end
         repeat (depth) frame_q.push_back(jpic_pkg::CLOSE_BRACE);
         repeat ($urandom_range(0, 2)) frame_q.push_back(pick_blank());
         if (kind < 30) begin
            pos = $urandom_range(0, frame_q.size() - 1);
            case ($urandom_range(0, 2))
               0: frame_q.delete(pos);
               1: frame_q.insert(pos, pick_struct());
               default: frame_q[pos] = 8'($urandom_range(0, 255));
            endcase
            if (frame_q.size() == 0) frame_q.push_back(pick_struct());
         end
      end
   endtask

   task automatic send_frame();
      bit eager;
      build_payload();
      eager = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < frame_q.size(); i++)
         push_byte(frame_q[i], i == frame_q.size() - 1, eager ? 0 : $urandom_range(0, 18));
      random_bytes += frame_q.size();
   endtask

   initial begin : rsp_side
      int stall;
      jpic_pkg::reason_type want;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         stall = rsp_eager ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (verdict_q.size() == 0) begin
            $error("unexpected rsp item: intact=%0b fail_reason=%0d",
                   rsp_intact, rsp_fail_reason);
            fault_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_intact !== (want == jpic_pkg::REASON_OK)) begin
               $error("intact: expected %0b, got %0b", want == jpic_pkg::REASON_OK,
                      rsp_intact);
               fault_count++;
            end
            if (rsp_fail_reason !== want) begin
               $error("fail_reason: expected %0d, got %0d", want, rsp_fail_reason);
               fault_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int i, k, len, phase, phase_end;
      logic [jpic_pkg::MAX_BYTES_W-1:0] limit_pick;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++)
         push_byte(dir_rows[i].b, dir_rows[i].last, $urandom_range(0, 3),
                   dir_rows[i].typed, dir_rows[i].why);

      // length limit boundary: longest intact payload, then one byte too many
      wait_idle();
      write_max(16'd64);
      for (k = 0; k < 2; k++) begin
         len = 64 + k;
         for (i = 0; i < len; i++)
            push_byte(i == 0 ? jpic_pkg::OPEN_BRACE :
                      (i == len - 1 ? jpic_pkg::CLOSE_BRACE : pick_blank()),
                      i == len - 1, 0, 1'b1,
                      k ? jpic_pkg::REASON_TOO_LONG : jpic_pkg::REASON_OK);
      end

      wait_idle();
      write_max(16'd1);
      push_byte(jpic_pkg::OPEN_BRACE, 1'b1, 0, 1'b1, jpic_pkg::REASON_FRAMING);
      push_byte(jpic_pkg::OPEN_BRACE, 1'b0, 0);
      push_byte(jpic_pkg::CLOSE_BRACE, 1'b1, 0, 1'b1, jpic_pkg::REASON_TOO_LONG);

      phase = 0;
      while (random_bytes < ITEM_GOAL) begin
         wait_idle();
         case (phase % 5)
            0: limit_pick = 16'($urandom_range(2, 48));
            1: limit_pick = 16'hFFFF;
            2: limit_pick = 16'($urandom_range(1, 65535));
            3: limit_pick = jpic_pkg::MAX_BYTES_RESET;
            default: limit_pick = 16'd1;
         endcase
         write_max(limit_pick);
         rsp_eager = ($urandom_range(0, 2) == 0);
         if (phase == 2) begin
            // stall the receiver so the result register fills and input backs up
            rsp_hold = 300;
            repeat (12) begin
               push_byte(jpic_pkg::OPEN_BRACE, 1'b0, 0);
               push_byte(jpic_pkg::CLOSE_BRACE, 1'b1, 0);
            end
            wait_idle();
         end
         phase_end = random_bytes + 200;
         while (random_bytes < phase_end) send_frame();
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fault_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
